// ----- sv/chuf_pkg.sv -----
package chuf_pkg;

    localparam int SYMBOL_BITS  = 9;
    localparam int MAX_CODE_LEN = 32;
    localparam int SYM_DEPTH    = 1 << SYMBOL_BITS;

    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 10;
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int CIDX_W  = $clog2(MAX_CODE_LEN);
    // generation tag kept with each table entry; tag zero never matches
    localparam int TAG_W   = 8;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COUNT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd3;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic clear;
        logic load_count;
        logic step;
    } bld_ctl_t;

    typedef struct packed {
        logic assign_now;
        logic finish;
        logic overrun;
    } bld_stat_t;

endpackage

// ----- sv/chuf_ram.sv -----
module chuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/chuf_builder.sv -----
module chuf_builder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  chuf_pkg::bld_ctl_t             ctl,
    input  logic [chuf_pkg::SLOT_W-1:0]    slot,
    input  logic [chuf_pkg::COUNT_W-1:0]   count_in,
    output chuf_pkg::bld_stat_t            stat,
    output logic [chuf_pkg::CODE_W-1:0]    code,
    output logic [chuf_pkg::LEN_W-1:0]     len
);

    localparam logic [chuf_pkg::LEN_W-1:0]  LEN_MAX  = chuf_pkg::LEN_W'(chuf_pkg::MAX_CODE_LEN);
    localparam logic [chuf_pkg::SLOT_W-1:0] SLOT_MAX = chuf_pkg::SLOT_W'(chuf_pkg::MAX_CODE_LEN);

    logic [chuf_pkg::COUNT_W-1:0] counts_reg  [chuf_pkg::MAX_CODE_LEN];
    logic [chuf_pkg::COUNT_W-1:0] counts_next [chuf_pkg::MAX_CODE_LEN];
    logic [chuf_pkg::LEN_W-1:0]   cur_reg, cur_next;
    logic [chuf_pkg::LEN_W-1:0]   ncl_reg, ncl_next;
    logic [chuf_pkg::COUNT_W-1:0] taken_reg, taken_next;
    logic [chuf_pkg::CODE_W-1:0]  code_reg, code_next;
    logic                         overrun_reg, overrun_next;

    logic                         in_range;
    logic [chuf_pkg::CIDX_W-1:0]  cnt_idx;
    logic [chuf_pkg::CIDX_W-1:0]  slot_idx;

    assign code = code_reg;
    assign len  = cur_reg;

    always_comb
    begin
        in_range     = (cur_reg <= LEN_MAX);
        cnt_idx      = chuf_pkg::CIDX_W'(cur_reg - chuf_pkg::LEN_W'(1));
        slot_idx     = chuf_pkg::CIDX_W'(slot - chuf_pkg::SLOT_W'(1));
        counts_next  = counts_reg;
        cur_next     = cur_reg;
        ncl_next     = ncl_reg;
        taken_next   = taken_reg;
        code_next    = code_reg;
        overrun_next = overrun_reg;
        stat         = '0;

        if (ctl.clear)
        begin
            for (int i = 0; i < chuf_pkg::MAX_CODE_LEN; i++)
            begin
                counts_next[i] = '0;
            end
            cur_next     = chuf_pkg::LEN_W'(1);
            ncl_next     = '0;
            taken_next   = '0;
            code_next    = '0;
            overrun_next = 1'b0;
        end
        else
        begin
            if (ctl.load_count && (slot != '0) && (slot <= SLOT_MAX))
            begin
                counts_next[slot_idx] = count_in;
            end
            // one step a cycle while step is high: skip a used-up length, add one code bit, assign, or flag an overrun
            if (ctl.step)
            begin
                priority if (!in_range)
                begin
                    overrun_next = 1'b1;
                    stat.finish  = 1'b1;
                end
                else if (taken_reg >= counts_reg[cnt_idx])
                begin
                    cur_next   = cur_reg + chuf_pkg::LEN_W'(1);
                    taken_next = '0;
                end
                else if (ncl_reg < cur_reg)
                begin
                    code_next = {code_reg[chuf_pkg::CODE_W-2:0], 1'b0};
                    ncl_next  = ncl_reg + chuf_pkg::LEN_W'(1);
                end
                else
                begin
                    stat.assign_now = 1'b1;
                    stat.finish     = 1'b1;
                    code_next       = code_reg + chuf_pkg::CODE_W'(1);
                    taken_next      = taken_reg + chuf_pkg::COUNT_W'(1);
                end
            end
        end
        stat.overrun = overrun_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < chuf_pkg::MAX_CODE_LEN; i++)
            begin
                counts_reg[i] <= '0;
            end
            cur_reg     <= chuf_pkg::LEN_W'(1);
            ncl_reg     <= '0;
            taken_reg   <= '0;
            code_reg    <= '0;
            overrun_reg <= 1'b0;
        end
        else
        begin
            counts_reg  <= counts_next;
            cur_reg     <= cur_next;
            ncl_reg     <= ncl_next;
            taken_reg   <= taken_next;
            code_reg    <= code_next;
            overrun_reg <= overrun_next;
        end
    end

endmodule

// ----- sv/canonical_huffman_encoder.sv -----
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------------------
// input    | start & !busy         | kind, length_slot, count_value, symbol
// result   | done (1-cycle strobe) | code_word, code_length, missing_symbol,
//          |                       | table_overrun
//
// Clear and count-load items act in their accept cycle; an encode item reads the
// table, then registers the result and done. A symbol load is accepted, then the
// builder takes one step per cycle, skipping used-up lengths and adding code bits,
// until it assigns the code or overruns. Results cannot be held off: done is high
// for a single cycle and the result holds until the next encode. After reset, and on
// every 255th clear, a sweep of all 512 entries retags the table; busy stays high.
module canonical_huffman_encoder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [chuf_pkg::KIND_W-1:0]        kind,
    input  logic [chuf_pkg::SLOT_W-1:0]        length_slot,
    input  logic [chuf_pkg::COUNT_W-1:0]       count_value,
    input  logic [chuf_pkg::SYMBOL_BITS-1:0]   symbol,
    output logic                               done,
    output logic [chuf_pkg::CODE_W-1:0]        code_word,
    output logic [chuf_pkg::LEN_W-1:0]         code_length,
    output logic                               missing_symbol,
    output logic                               table_overrun
);

    localparam logic [1:0] ST_SWEEP = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_BUILD = 2'd2;
    localparam logic [1:0] ST_ENC   = 2'd3;

    logic [1:0]                         state_reg, state_next;
    logic [chuf_pkg::SYMBOL_BITS-1:0]   sweep_reg, sweep_next;
    logic [chuf_pkg::TAG_W-1:0]         epoch_reg, epoch_next;
    logic [chuf_pkg::SYMBOL_BITS-1:0]   sym_reg, sym_next;
    logic                               done_reg, done_next;
    logic [chuf_pkg::CODE_W-1:0]        word_reg, word_next;
    logic [chuf_pkg::LEN_W-1:0]         len_reg, len_next;
    logic                               miss_reg, miss_next;
    logic                               ovr_reg, ovr_next;

    logic                               accept;
    chuf_pkg::bld_ctl_t                 ctl;
    chuf_pkg::bld_stat_t                stat;
    logic [chuf_pkg::CODE_W-1:0]        bld_code;
    logic [chuf_pkg::LEN_W-1:0]         bld_len;

    logic                               wr_en;
    logic [chuf_pkg::SYMBOL_BITS-1:0]   wr_addr;
    chuf_pkg::entry_t                   wr_entry;
    logic                               rd_en;
    chuf_pkg::entry_t                   rd_entry;
    logic                               hit;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign ctl.clear      = accept && (kind == chuf_pkg::KIND_CLEAR);
    assign ctl.load_count = accept && (kind == chuf_pkg::KIND_COUNT);
    assign ctl.step       = (state_reg == ST_BUILD);

    chuf_builder u_builder (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .slot     (length_slot),
        .count_in (count_value),
        .stat     (stat),
        .code     (bld_code),
        .len      (bld_len)
    );

    always_comb
    begin
        wr_en         = (state_reg == ST_SWEEP) || ((state_reg == ST_BUILD) && stat.assign_now);
        wr_addr       = (state_reg == ST_SWEEP) ? sweep_reg : sym_reg;
        wr_entry.tag  = (state_reg == ST_SWEEP) ? '0 : epoch_reg;
        wr_entry.len  = bld_len;
        wr_entry.code = bld_code;
    end

    assign rd_en = accept && (kind == chuf_pkg::KIND_ENCODE);

    chuf_ram #(
        .WIDTH (chuf_pkg::ENTRY_W),
        .DEPTH (chuf_pkg::SYM_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (symbol),
        .rd_data (rd_entry)
    );

    assign hit = (rd_entry.tag == epoch_reg);

    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        epoch_next = epoch_reg;
        sym_next   = sym_reg;
        done_next  = 1'b0;
        word_next  = word_reg;
        len_next   = len_reg;
        miss_next  = miss_reg;
        ovr_next   = ovr_reg;

        unique case (state_reg)
            ST_SWEEP:
            begin
                sweep_next = sweep_reg + chuf_pkg::SYMBOL_BITS'(1);
                if (&sweep_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    sym_next = symbol;
                    unique case (kind)
                        chuf_pkg::KIND_CLEAR:
                        begin
                            // retire all entries by moving to a fresh tag
                            if (&epoch_reg)
                            begin
                                epoch_next = chuf_pkg::TAG_W'(1);
                                state_next = ST_SWEEP;
                            end
                            else
                            begin
                                epoch_next = epoch_reg + chuf_pkg::TAG_W'(1);
                            end
                        end
                        chuf_pkg::KIND_COUNT:
                        begin
                            state_next = ST_IDLE;
                        end
                        chuf_pkg::KIND_LOAD:
                        begin
                            state_next = ST_BUILD;
                        end
                        chuf_pkg::KIND_ENCODE:
                        begin
                            state_next = ST_ENC;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_BUILD:
            begin
                if (stat.finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ENC:
            begin
                done_next  = 1'b1;
                word_next  = hit ? rd_entry.code : '0;
                len_next   = hit ? rd_entry.len : '0;
                miss_next  = !hit;
                ovr_next   = stat.overrun;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
            sweep_reg <= '0;
            epoch_reg <= chuf_pkg::TAG_W'(1);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            epoch_reg <= epoch_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg  <= sym_next;
        word_reg <= word_next;
        len_reg  <= len_next;
        miss_reg <= miss_next;
        ovr_reg  <= ovr_next;
    end

    assign done           = done_reg;
    assign code_word      = word_reg;
    assign code_length    = len_reg;
    assign missing_symbol = miss_reg;
    assign table_overrun  = ovr_reg;

endmodule

// ----- sv/chuf_checker.sv -----
module chuf_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic [chuf_pkg::KIND_W-1:0]        kind,
    input logic                               done,
    input logic [chuf_pkg::CODE_W-1:0]        code_word,
    input logic [chuf_pkg::LEN_W-1:0]         code_length,
    input logic                               missing_symbol
);

    // an encode item yields its result after the table read and the result register
    a_enc_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == chuf_pkg::KIND_ENCODE)) |-> ##2 done)
        else $error("encode item without result");

    // non-encode items never produce a result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind != chuf_pkg::KIND_ENCODE)) |-> ##2 !done)
        else $error("result without encode item");

    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && missing_symbol) |-> ((code_word == '0) && (code_length == '0)))
        else $error("missing symbol with nonzero code");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !missing_symbol) |->
            ((code_length != '0) &&
             (code_length <= chuf_pkg::LEN_W'(chuf_pkg::MAX_CODE_LEN))))
        else $error("assigned code length out of range");

endmodule

bind canonical_huffman_encoder chuf_checker u_chuf_checker (.*);

// ----- tb/tb_canonical_huffman_encoder.sv -----
`timescale 1ns / 100ps

module tb_canonical_huffman_encoder;

    import chuf_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [CODE_W-1:0] word;
        logic [LEN_W-1:0]  len;
        logic              miss;
        logic              ovr;
    } code_result_t;

    typedef struct {
        logic [KIND_W-1:0]      kind;
        logic [SLOT_W-1:0]      slot;
        logic [COUNT_W-1:0]     cnt;
        logic [SYMBOL_BITS-1:0] sym;
        bit                     typed;
        code_result_t           want;
    } stim_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [KIND_W-1:0]       kind = '0;
    logic [SLOT_W-1:0]       length_slot = '0;
    logic [COUNT_W-1:0]      count_value = '0;
    logic [SYMBOL_BITS-1:0]  symbol = '0;
    logic                    done;
    logic [CODE_W-1:0]       code_word;
    logic [LEN_W-1:0]        code_length;
    logic                    missing_symbol;
    logic                    table_overrun;

    // predictor state
    logic [COUNT_W-1:0]      len_counts [MAX_CODE_LEN];
    logic [CODE_W-1:0]       word_table [SYM_DEPTH];
    logic [LEN_W-1:0]        len_table  [SYM_DEPTH];
    bit                      has_code   [SYM_DEPTH];
    int                      bld_len;
    logic [COUNT_W-1:0]      bld_taken;
    logic [CODE_W-1:0]       bld_code;
    int                      bld_code_len;
    bit                      overrun_seen;

    code_result_t            expected_codes [$];
    stim_row_t               directed_rows [$];

    int mismatches   = 0;
    int items_sent   = 0;
    int encodes_sent = 0;
    int results_seen = 0;
    int builds_run   = 0;
    int overrun_hits = 0;
    int idle_pct     = 0;

    canonical_huffman_encoder DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .length_slot    (length_slot),
        .count_value    (count_value),
        .symbol         (symbol),
        .done           (done),
        .code_word      (code_word),
        .code_length    (code_length),
        .missing_symbol (missing_symbol),
        .table_overrun  (table_overrun)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [CODE_W-1:0] got,
                                   input logic [CODE_W-1:0] want);
        mismatches++;
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    endtask

    task automatic add_row(input stim_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic clear_code_table();
        for (int i = 0; i < MAX_CODE_LEN; i++)
            len_counts[i] = '0;
        for (int i = 0; i < SYM_DEPTH; i++)
            has_code[i] = 1'b0;
        bld_len      = 1;
        bld_taken    = '0;
        bld_code     = '0;
        bld_code_len = 0;
        overrun_seen = 1'b0;
    endtask

    // Apply one item to the predictor; returns the code lookup for encodes.
    task automatic predict_code(input stim_row_t row, output bit has_result,
                                output code_result_t res, output bit took_effect);
        has_result  = 1'b0;
        took_effect = 1'b1;
        res         = '{word: '0, len: '0, miss: 1'b0, ovr: 1'b0};
        case (row.kind)
            KIND_CLEAR:
                clear_code_table();
            KIND_COUNT:
            begin
                if (row.slot >= 1 && row.slot <= MAX_CODE_LEN)
                    len_counts[row.slot - 1] = row.cnt;
                else
                    took_effect = 1'b0;
            end
            KIND_LOAD:
            begin
                // skip lengths whose counts are used up
                while (bld_len <= MAX_CODE_LEN && bld_taken >= len_counts[bld_len - 1])
                begin
                    bld_len++;
                    bld_taken = '0;
                end
                if (bld_len > MAX_CODE_LEN)
                begin
                    overrun_seen = 1'b1;
                    took_effect  = 1'b0;
                    overrun_hits++;
                end
                else
                begin
                    while (bld_code_len < bld_len)
                    begin
                        bld_code = bld_code << 1;
                        bld_code_len++;
                    end
                    word_table[row.sym] = bld_code;
                    len_table[row.sym]  = LEN_W'(bld_len);
                    has_code[row.sym]   = 1'b1;
                    bld_code  = bld_code + CODE_W'(1);
                    bld_taken = bld_taken + COUNT_W'(1);
                end
            end
            default:
            begin
                has_result = 1'b1;
                if (has_code[row.sym])
                begin
                    res.word = word_table[row.sym];
                    res.len  = len_table[row.sym];
                end
                else
                    res.miss = 1'b1;
                res.ovr = overrun_seen;
            end
        endcase
    endtask

    function automatic stim_row_t make_row(input logic [KIND_W-1:0] k,
                                           input int slot,
                                           input int cnt,
                                           input int s);
        stim_row_t row;
        row.kind  = k;
        row.slot  = SLOT_W'(slot);
        row.cnt   = COUNT_W'(cnt);
        row.sym   = SYMBOL_BITS'(s);
        row.typed = 1'b0;
        row.want  = '{word: '0, len: '0, miss: 1'b0, ovr: 1'b0};
        return row;
    endfunction

    function automatic stim_row_t with_result(input stim_row_t row, input int w,
                                              input int l, input int m,
                                              input int o);
        stim_row_t r;
        r       = row;
        r.typed = 1'b1;
        r.want  = '{word: CODE_W'(w), len: LEN_W'(l), miss: m[0], ovr: o[0]};
        return r;
    endfunction

    // Present one item, hold until accepted, then idle a random gap.
    task automatic send_item(input stim_row_t row);
        bit           has_result;
        bit           took_effect;
        code_result_t res;
        int           gap;
        start       <= 1'b1;
        kind        <= row.kind;
        length_slot <= row.slot;
        count_value <= row.cnt;
        symbol      <= row.sym;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_code(row, has_result, res, took_effect);
        if (has_result)
        begin
            expected_codes.insert(expected_codes.size(), row.typed ? row.want : res);
            encodes_sent++;
        end
        if (took_effect)
            items_sent++;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_noise();
        if ($urandom_range(19) == 0)
            send_item(make_row(KIND_W'($urandom_range(3)), $urandom, $urandom, $urandom));
    endtask

    // Clear, load a count table, load symbols in canonical order, encode.
    task automatic random_build();
        int                     span;
        int                     total;
        int                     n_load;
        int                     cnt;
        logic [SYMBOL_BITS-1:0] s;
        logic [SYMBOL_BITS-1:0] loaded [$];
        builds_run++;
        send_item(make_row(KIND_CLEAR, $urandom, $urandom, $urandom));
        span  = ($urandom_range(9) == 0) ? MAX_CODE_LEN : $urandom_range(8, 1);
        total = 0;
        for (int l = 1; l <= span; l++)
        begin
            if ($urandom_range(2) != 0 || l == span)
            begin
                cnt = (total > 20) ? 0 : $urandom_range(4);
                if (l == span && total == 0)
                    cnt = $urandom_range(4, 1);
                send_noise();
                send_item(make_row(KIND_COUNT, l, cnt, $urandom));
                total += cnt;
            end
        end
        n_load = total;
        if ($urandom_range(6) == 0)
            n_load += $urandom_range(3, 1);
        for (int i = 0; i < n_load; i++)
        begin
            s = SYMBOL_BITS'($urandom);
            loaded.insert(loaded.size(), s);
            send_noise();
            send_item(make_row(KIND_LOAD, $urandom, $urandom, int'(s)));
        end
        for (int i = 0; i < n_load + 4; i++)
        begin
            if (loaded.size() > 0 && $urandom_range(4) != 0)
                s = loaded[$urandom_range(loaded.size() - 1)];
            else
                s = SYMBOL_BITS'($urandom);
            send_noise();
            send_item(make_row(KIND_ENCODE, $urandom, $urandom, int'(s)));
        end
    endtask

    always @(posedge clk)
    begin
        code_result_t want;
        if (rst_n && done === 1'b1)
        begin
            results_seen++;
            if (expected_codes.size() == 0)
                report_mismatch("unexpected result, code_word", code_word, '0);
            else
            begin
                want = expected_codes.pop_front();
                if (code_word !== want.word)
                    report_mismatch("code_word", code_word, want.word);
                if (code_length !== want.len)
                    report_mismatch("code_length", CODE_W'(code_length), CODE_W'(want.len));
                if (missing_symbol !== want.miss)
                    report_mismatch("missing_symbol", CODE_W'(missing_symbol),
                                    CODE_W'(want.miss));
                if (table_overrun !== want.ovr)
                    report_mismatch("table_overrun", CODE_W'(table_overrun),
                                    CODE_W'(want.ovr));
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d results outstanding", expected_codes.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int target;
        clear_code_table();

        // empty table, then a tiny code set with one length-32 code and an overrun
        add_row(with_result(make_row(KIND_ENCODE, 0, 0, 0), 0, 0, 1, 0));
        add_row(with_result(make_row(KIND_ENCODE, 63, 1023, 511), 0, 0, 1, 0));
        add_row(make_row(KIND_COUNT, 0, 5, 0));
        add_row(make_row(KIND_COUNT, 63, 1023, 511));
        add_row(make_row(KIND_COUNT, 1, 1, 0));
        add_row(make_row(KIND_COUNT, 2, 1, 0));
        add_row(make_row(KIND_COUNT, 32, 1, 0));
        add_row(make_row(KIND_LOAD, 0, 0, 0));
        add_row(make_row(KIND_LOAD, 63, 1023, 511));
        add_row(make_row(KIND_LOAD, 0, 0, 7));
        add_row(make_row(KIND_LOAD, 0, 0, 8));
        add_row(with_result(make_row(KIND_ENCODE, 0, 0, 0), 0, 1, 0, 1));
        add_row(with_result(make_row(KIND_ENCODE, 0, 0, 511), 2, 2, 0, 1));
        add_row(with_result(make_row(KIND_ENCODE, 0, 0, 7), 32'hC000_0000, 32, 0, 1));
        add_row(with_result(make_row(KIND_ENCODE, 0, 0, 8), 0, 0, 1, 1));
        add_row(make_row(KIND_CLEAR, 63, 1023, 511));
        add_row(with_result(make_row(KIND_ENCODE, 0, 0, 0), 0, 0, 1, 0));
        // oversized count wraps the code; reload, then lower a count mid-build
        add_row(make_row(KIND_COUNT, 1, 1023, 0));
        add_row(make_row(KIND_LOAD, 0, 0, 3));
        add_row(make_row(KIND_LOAD, 0, 0, 3));
        add_row(make_row(KIND_COUNT, 1, 0, 0));
        add_row(make_row(KIND_COUNT, 5, 2, 0));
        add_row(make_row(KIND_LOAD, 0, 0, 4));
        add_row(make_row(KIND_ENCODE, 0, 0, 3));
        add_row(make_row(KIND_ENCODE, 0, 0, 4));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            // phases: no idling, heavy sender gaps, moderate gaps, no idling
            case ((4 * (target - items_sent - 1)) / RANDOM_ITEMS)
                3: idle_pct = 0;
                2: idle_pct = 58;
                1: idle_pct = 35;
                default: idle_pct = 0;
            endcase
            random_build();
        end
        start <= 1'b0;

        while (expected_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d items in %0d table builds: %0d encodes, %0d results checked",
                 items_sent, builds_run, encodes_sent, results_seen);
        $display("overrun loads %0d, mismatches %0d", overrun_hits, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/chuf_pkg.sv
sv/chuf_ram.sv
sv/chuf_builder.sv
sv/canonical_huffman_encoder.sv
sv/chuf_checker.sv
tb/tb_canonical_huffman_encoder.sv
